// ===== design/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants, types and functions of the 32-bit twister generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int SHIFT_OFFSET = 397;
	localparam int KEY_DEPTH    = 64;

	localparam int WORD_W      = 32;
	localparam int SW_ADDR_W   = $clog2(STATE_WORDS);
	localparam int POS_W       = $clog2(STATE_WORDS + 2);
	localparam int KEY_ADDR_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int KEY_SLOT_W  = 6;
	localparam int KEY_CNT_W   = 7;
	localparam int CFG_INDEX_W = 2;

	localparam logic [POS_W-1:0] POS_EXHAUSTED   = POS_W'(STATE_WORDS);
	localparam logic [POS_W-1:0] POS_NEVER_SEEDED = POS_W'(STATE_WORDS + 1);

	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
	localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
	localparam logic [WORD_W-1:0] KEY_MULT_A   = 32'd1664525;
	localparam logic [WORD_W-1:0] KEY_MULT_B   = 32'd1566083941;
	localparam logic [WORD_W-1:0] KEY_SEED     = 32'd19650218;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

	localparam logic [KEY_CNT_W-1:0] KEY_COUNT_RESET = KEY_CNT_W'(1);

	typedef enum logic [1:0] {
		CMD_NEXT      = 2'd0,
		CMD_SEED      = 2'd1,
		CMD_KEY_WRITE = 2'd2,
		CMD_KEY_FILL  = 2'd3
	} cmd_t;

	localparam logic [CFG_INDEX_W-1:0] CFG_SEED_VALUE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_COUNT  = CFG_INDEX_W'(1);

	typedef struct packed {
		logic                 we;
		logic [SW_ADDR_W-1:0] waddr;
		logic [WORD_W-1:0]    wdata;
		logic [SW_ADDR_W-1:0] raddr_a;
		logic [SW_ADDR_W-1:0] raddr_b;
	} tsr_req_t;

	typedef struct packed {
		logic                  we;
		logic [KEY_ADDR_W-1:0] waddr;
		logic [WORD_W-1:0]     wdata;
		logic [KEY_ADDR_W-1:0] raddr;
	} key_req_t;

	function automatic logic [WORD_W-1:0] fold30(input logic [WORD_W-1:0] w);
		return w ^ (w >> 30);
	endfunction

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// ===== design/mtg_cmd_if.sv =====
// ----------------------------------------------------------------------------
// mtg_cmd_if
// Command channel: one item per command with key slot and key data.
// ----------------------------------------------------------------------------
interface mtg_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        command;
	logic [mtg_pkg::KEY_SLOT_W-1:0]    key_slot;
	logic [mtg_pkg::WORD_W-1:0]        key_data;

	modport source (output valid, output command, output key_slot, output key_data,
		input ready);
	modport sink (input valid, input command, input key_slot, input key_data,
		output ready);
endinterface

// ===== design/mtg_word_if.sv =====
// ----------------------------------------------------------------------------
// mtg_word_if
// Result channel: one tempered random word per item.
// ----------------------------------------------------------------------------
interface mtg_word_if;
	logic                       valid;
	logic                       ready;
	logic [mtg_pkg::WORD_W-1:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink (input valid, input random_word, output ready);
endinterface

// ===== design/mtg_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mtg_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mtg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mtg_pkg::CFG_INDEX_W-1:0] index;
	logic [mtg_pkg::WORD_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/mtg_ram.sv =====
// ----------------------------------------------------------------------------
// mtg_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr_a,
	output logic [WIDTH-1:0]                 rdata_a,
	input  logic [$clog2(DEPTH)-1:0]         raddr_b,
	output logic [WIDTH-1:0]                 rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== design/mtg_out.sv =====
// ----------------------------------------------------------------------------
// mtg_out
// Tempering and output buffer: output register plus one skid entry.
// ----------------------------------------------------------------------------
module mtg_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       word_valid,
	input  logic [mtg_pkg::WORD_W-1:0] word,
	output logic                       room,
	mtg_word_if.source                 rsp
);

	logic                       out_valid_q;
	logic [mtg_pkg::WORD_W-1:0] out_q;
	logic                       skid_valid_q;
	logic [mtg_pkg::WORD_W-1:0] skid_q;
	logic [mtg_pkg::WORD_W-1:0] tempered;
	logic                       pop;
	logic [1:0]                 occupancy;

	assign tempered        = mtg_pkg::temper(word);
	assign pop             = out_valid_q && rsp.ready;
	assign occupancy       = 2'(word_valid) + 2'(out_valid_q) + 2'(skid_valid_q);
	assign room            = (occupancy < 2'd2);
	assign rsp.valid       = out_valid_q;
	assign rsp.random_word = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q        <= skid_q;
				out_valid_q  <= 1'b1;
				skid_valid_q <= word_valid;
				skid_q       <= tempered;
			end else begin
				out_q       <= tempered;
				out_valid_q <= word_valid;
			end
		end else if (word_valid) begin
			skid_q       <= tempered;
			skid_valid_q <= 1'b1;
		end
	end

endmodule

// ===== design/mtg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtg_ctrl
// Sequencer: command decode, registers, seeding, key fill and twist passes
// over the state store, and word reads for generation.
// ----------------------------------------------------------------------------
module mtg_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	mtg_cmd_if.sink                    cmd,
	mtg_cfg_if.sink                    cfg,
	input  logic                       room,
	output logic                       word_valid,
	output mtg_pkg::tsr_req_t          tsr_req,
	input  logic [mtg_pkg::WORD_W-1:0] tsr_rdata_a,
	input  logic [mtg_pkg::WORD_W-1:0] tsr_rdata_b,
	output mtg_pkg::key_req_t          key_req,
	input  logic [mtg_pkg::WORD_W-1:0] key_rdata
);

	localparam logic [mtg_pkg::SW_ADDR_W-1:0] LAST_IDX =
		mtg_pkg::SW_ADDR_W'(mtg_pkg::STATE_WORDS - 1);
	localparam logic [mtg_pkg::SW_ADDR_W-1:0] FAR_WRAP =
		mtg_pkg::SW_ADDR_W'(mtg_pkg::STATE_WORDS - mtg_pkg::SHIFT_OFFSET);
	localparam logic [mtg_pkg::SW_ADDR_W-1:0] FAR_STEP =
		mtg_pkg::SW_ADDR_W'(mtg_pkg::SHIFT_OFFSET);
	localparam logic [mtg_pkg::SW_ADDR_W-1:0] MIX_LAST =
		mtg_pkg::SW_ADDR_W'(mtg_pkg::STATE_WORDS - 1);
	localparam logic [mtg_pkg::SW_ADDR_W-1:0] DIFFUSE_LAST =
		mtg_pkg::SW_ADDR_W'(mtg_pkg::STATE_WORDS - 2);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_ADD,
		ST_KEY_RD,
		ST_KEY_WR,
		ST_KEY_FIN,
		ST_TW_PRE,
		ST_TW_RUN,
		ST_TW_LAST
	} state_t;

	state_t                                state_q;
	logic [mtg_pkg::POS_W-1:0]             pos_q;
	logic                                  gen_pend_q;
	logic                                  key_mode_q;
	logic                                  twist_after_q;
	logic                                  diffuse_q;
	logic [mtg_pkg::SW_ADDR_W-1:0]         idx_q;
	logic [mtg_pkg::SW_ADDR_W-1:0]         cnt_q;
	logic [mtg_pkg::KEY_ADDR_W-1:0]        j_q;
	logic [mtg_pkg::KEY_CNT_W-1:0]         len_q;
	logic [mtg_pkg::WORD_W-1:0]            prev_q;
	logic [mtg_pkg::WORD_W-1:0]            prod_s1;
	logic                                  hi_q;
	logic                                  tw_v_s1;
	logic [mtg_pkg::SW_ADDR_W-1:0]         widx_s1;
	logic                                  rd_s1;
	logic [mtg_pkg::WORD_W-1:0]            seed_value_q;
	logic [mtg_pkg::KEY_CNT_W-1:0]         key_count_q;

	logic                                  accept;
	mtg_pkg::cmd_t                         op;
	logic [mtg_pkg::SW_ADDR_W-1:0]         nxt_idx;
	logic [mtg_pkg::SW_ADDR_W-1:0]         far_idx;
	logic [mtg_pkg::WORD_W-1:0]            seed_val;
	logic [mtg_pkg::WORD_W-1:0]            mix;
	logic [mtg_pkg::WORD_W-1:0]            key_val;
	logic [mtg_pkg::WORD_W-1:0]            tw_y;
	logic [mtg_pkg::WORD_W-1:0]            tw_val;
	logic [mtg_pkg::KEY_CNT_W-1:0]         len_clamped;
	logic                                  j_wrap;
	logic                                  pos_ok;

	assign op        = mtg_pkg::cmd_t'(cmd.command);
	assign cmd.ready = (state_q == ST_IDLE) && !gen_pend_q && room;
	assign accept    = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign word_valid = rd_s1;
	assign pos_ok    = (pos_q < mtg_pkg::POS_EXHAUSTED);

	assign nxt_idx  = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign far_idx  = (idx_q >= FAR_WRAP) ? idx_q - FAR_WRAP : idx_q + FAR_STEP;
	assign seed_val = prod_s1 + mtg_pkg::WORD_W'(idx_q);
	assign mix      = tsr_rdata_a ^ prod_s1;
	assign key_val  = diffuse_q ? mix - mtg_pkg::WORD_W'(idx_q)
		: mix + key_rdata + mtg_pkg::WORD_W'(j_q);
	assign tw_y     = {hi_q, tsr_rdata_a[mtg_pkg::WORD_W-2:0]};
	assign tw_val   = tsr_rdata_b ^ (tw_y >> 1) ^ (tw_y[0] ? mtg_pkg::TWIST_MATRIX : '0);
	assign j_wrap   = (mtg_pkg::KEY_CNT_W'(j_q) + 1'b1) == len_q;

	always_comb begin
		if (key_count_q == '0) begin
			len_clamped = mtg_pkg::KEY_CNT_W'(1);
		end else if (int'(key_count_q) > mtg_pkg::KEY_DEPTH) begin
			len_clamped = mtg_pkg::KEY_CNT_W'(mtg_pkg::KEY_DEPTH);
		end else begin
			len_clamped = key_count_q;
		end
	end

	always_comb begin
		key_req.we    = accept && (op == mtg_pkg::CMD_KEY_WRITE)
			&& (int'(cmd.key_slot) < mtg_pkg::KEY_DEPTH);
		key_req.waddr = mtg_pkg::KEY_ADDR_W'(cmd.key_slot);
		key_req.wdata = cmd.key_data;
		key_req.raddr = j_q;
	end

	always_comb begin
		tsr_req.we      = 1'b0;
		tsr_req.waddr   = idx_q;
		tsr_req.wdata   = seed_val;
		tsr_req.raddr_a = idx_q;
		tsr_req.raddr_b = far_idx;
		unique case (state_q)
			ST_IDLE: begin
				tsr_req.raddr_a = pos_q[mtg_pkg::SW_ADDR_W-1:0];
			end
			ST_SEED_MUL: begin
				tsr_req.we    = (idx_q == mtg_pkg::SW_ADDR_W'(1));
				tsr_req.waddr = '0;
				tsr_req.wdata = prev_q;
			end
			ST_SEED_ADD: begin
				tsr_req.we = 1'b1;
			end
			ST_KEY_RD: begin
				tsr_req.raddr_a = idx_q;
			end
			ST_KEY_WR: begin
				tsr_req.we    = 1'b1;
				tsr_req.wdata = key_val;
			end
			ST_KEY_FIN: begin
				tsr_req.we    = 1'b1;
				tsr_req.waddr = '0;
				tsr_req.wdata = mtg_pkg::HIGH_BIT;
			end
			ST_TW_PRE: begin
				tsr_req.raddr_a = '0;
			end
			ST_TW_RUN: begin
				tsr_req.raddr_a = nxt_idx;
				tsr_req.we      = tw_v_s1;
				tsr_req.waddr   = widx_s1;
				tsr_req.wdata   = tw_val;
			end
			ST_TW_LAST: begin
				tsr_req.we    = 1'b1;
				tsr_req.waddr = widx_s1;
				tsr_req.wdata = tw_val;
			end
			default: begin
				tsr_req.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pos_q         <= mtg_pkg::POS_NEVER_SEEDED;
			gen_pend_q    <= 1'b0;
			key_mode_q    <= 1'b0;
			twist_after_q <= 1'b0;
			diffuse_q     <= 1'b0;
			idx_q         <= '0;
			cnt_q         <= '0;
			j_q           <= '0;
			len_q         <= mtg_pkg::KEY_COUNT_RESET;
			prev_q        <= '0;
			prod_s1       <= '0;
			hi_q          <= 1'b0;
			tw_v_s1       <= 1'b0;
			widx_s1       <= '0;
			rd_s1         <= 1'b0;
			seed_value_q  <= mtg_pkg::DEFAULT_SEED;
			key_count_q   <= mtg_pkg::KEY_COUNT_RESET;
		end else begin
			rd_s1 <= 1'b0;

			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					mtg_pkg::CFG_SEED_VALUE: seed_value_q <= cfg.data;
					mtg_pkg::CFG_KEY_COUNT:  key_count_q  <= cfg.data[mtg_pkg::KEY_CNT_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (gen_pend_q) begin
						gen_pend_q <= 1'b0;
						rd_s1      <= 1'b1;
						pos_q      <= pos_q + 1'b1;
					end else if (accept) begin
						unique case (op)
							mtg_pkg::CMD_NEXT: begin
								if (pos_ok) begin
									rd_s1 <= 1'b1;
									pos_q <= pos_q + 1'b1;
								end else if (pos_q == mtg_pkg::POS_EXHAUSTED) begin
									gen_pend_q <= 1'b1;
									state_q    <= ST_TW_PRE;
								end else begin
									gen_pend_q    <= 1'b1;
									prev_q        <= mtg_pkg::DEFAULT_SEED;
									idx_q         <= mtg_pkg::SW_ADDR_W'(1);
									key_mode_q    <= 1'b0;
									twist_after_q <= 1'b1;
									state_q       <= ST_SEED_MUL;
								end
							end
							mtg_pkg::CMD_SEED: begin
								prev_q        <= seed_value_q;
								idx_q         <= mtg_pkg::SW_ADDR_W'(1);
								key_mode_q    <= 1'b0;
								twist_after_q <= 1'b0;
								state_q       <= ST_SEED_MUL;
							end
							mtg_pkg::CMD_KEY_FILL: begin
								prev_q        <= mtg_pkg::KEY_SEED;
								idx_q         <= mtg_pkg::SW_ADDR_W'(1);
								key_mode_q    <= 1'b1;
								twist_after_q <= 1'b0;
								len_q         <= len_clamped;
								state_q       <= ST_SEED_MUL;
							end
							default: ;
						endcase
					end
				end

				ST_SEED_MUL: begin
					prod_s1 <= mtg_pkg::SEED_MULT * mtg_pkg::fold30(prev_q);
					state_q <= ST_SEED_ADD;
				end

				ST_SEED_ADD: begin
					prev_q <= seed_val;
					if (idx_q == LAST_IDX) begin
						pos_q <= mtg_pkg::POS_EXHAUSTED;
						if (key_mode_q) begin
							prev_q    <= mtg_pkg::KEY_SEED;
							idx_q     <= mtg_pkg::SW_ADDR_W'(1);
							cnt_q     <= '0;
							j_q       <= '0;
							diffuse_q <= 1'b0;
							state_q   <= ST_KEY_RD;
						end else if (twist_after_q) begin
							state_q <= ST_TW_PRE;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SEED_MUL;
					end
				end

				ST_KEY_RD: begin
					prod_s1 <= mtg_pkg::fold30(prev_q)
						* (diffuse_q ? mtg_pkg::KEY_MULT_B : mtg_pkg::KEY_MULT_A);
					state_q <= ST_KEY_WR;
				end

				ST_KEY_WR: begin
					prev_q  <= key_val;
					idx_q   <= (idx_q == LAST_IDX) ? mtg_pkg::SW_ADDR_W'(1) : idx_q + 1'b1;
					j_q     <= j_wrap ? '0 : j_q + 1'b1;
					state_q <= ST_KEY_RD;
					if (!diffuse_q) begin
						if (cnt_q == MIX_LAST) begin
							cnt_q     <= '0;
							diffuse_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						if (cnt_q == DIFFUSE_LAST) begin
							state_q <= ST_KEY_FIN;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end

				ST_KEY_FIN: begin
					pos_q   <= mtg_pkg::POS_EXHAUSTED;
					state_q <= ST_IDLE;
				end

				ST_TW_PRE: begin
					idx_q   <= '0;
					tw_v_s1 <= 1'b0;
					state_q <= ST_TW_RUN;
				end

				ST_TW_RUN: begin
					hi_q    <= tsr_rdata_a[mtg_pkg::WORD_W-1];
					tw_v_s1 <= 1'b1;
					widx_s1 <= idx_q;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_TW_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end

				ST_TW_LAST: begin
					tw_v_s1 <= 1'b0;
					pos_q   <= '0;
					state_q <= ST_IDLE;
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// 32-bit twister pseudo-random generator with a 624-word state store.
//
// Channels: cmd takes command items (next word, reseed from seed_value,
// write key word, reseed from the key store); rsp returns one tempered word
// per next command; cfg writes seed_value (index 0) and key_count (index 1).
// A next word whose state word is ready passes the store read register and
// the tempering output register to rsp.valid. A next item may be taken
// while the last is in the read stage, but cmd.ready drops while one word
// is there and another sits in the output register. An exhausted store
// first runs a twist pass. A reseed from seed_value runs a multiply then
// an add for each word; a reseed from keys seeds alike from a fixed key
// seed, then runs mix and diffuse passes; a first next command after reset
// seeds with the default seed and twists before its word is read.
// Reset leaves the store unseeded and no work pending. A stalled receiver
// is absorbed by the output register plus one skid entry; cmd.ready drops
// while two words are held or in flight. Key writes complete in the
// accepting cycle.
// ----------------------------------------------------------------------------
module mersenne_twister_generator (
	input  logic       clk,
	input  logic       arst_n,
	mtg_cmd_if.sink    cmd,
	mtg_word_if.source rsp,
	mtg_cfg_if.sink    cfg
);

	mtg_pkg::tsr_req_t          tsr_req;
	mtg_pkg::key_req_t          key_req;
	logic [mtg_pkg::WORD_W-1:0] tsr_rdata_a;
	logic [mtg_pkg::WORD_W-1:0] tsr_rdata_b;
	logic [mtg_pkg::WORD_W-1:0] key_rdata;
	logic                       room;
	logic                       word_valid;

	mtg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.room        (room),
		.word_valid  (word_valid),
		.tsr_req     (tsr_req),
		.tsr_rdata_a (tsr_rdata_a),
		.tsr_rdata_b (tsr_rdata_b),
		.key_req     (key_req),
		.key_rdata   (key_rdata)
	);

	mtg_ram #(
		.WIDTH (mtg_pkg::WORD_W),
		.DEPTH (mtg_pkg::STATE_WORDS)
	) u_twist_store (
		.clk     (clk),
		.we      (tsr_req.we),
		.waddr   (tsr_req.waddr),
		.wdata   (tsr_req.wdata),
		.raddr_a (tsr_req.raddr_a),
		.rdata_a (tsr_rdata_a),
		.raddr_b (tsr_req.raddr_b),
		.rdata_b (tsr_rdata_b)
	);

	mtg_ram #(
		.WIDTH (mtg_pkg::WORD_W),
		.DEPTH (mtg_pkg::KEY_DEPTH)
	) u_key_store (
		.clk     (clk),
		.we      (key_req.we),
		.waddr   (key_req.waddr),
		.wdata   (key_req.wdata),
		.raddr_a (key_req.raddr),
		.rdata_a (key_rdata),
		.raddr_b (key_req.raddr),
		.rdata_b ()
	);

	mtg_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word       (tsr_rdata_a),
		.room       (room),
		.rsp        (rsp)
	);

endmodule
